// File: hdl/rtgn_pkg.sv
// Shared types, register map, opcodes and the per-pass microprogram for the undistortion engine.
`default_nettype none
package rtgn_pkg;

  localparam int MAX_PASSES_DEF = 16;
  localparam int FRAC_BITS_DEF  = 28;

  localparam int CFG_AW = 5;

  // configuration register indexes
  localparam logic [2:0] CFG_K1  = 3'd0;
  localparam logic [2:0] CFG_K2  = 3'd1;
  localparam logic [2:0] CFG_P1  = 3'd2;
  localparam logic [2:0] CFG_P2  = 3'd3;
  localparam logic [2:0] CFG_TOL = 3'd4;

  localparam int RF_AW  = 5;
  localparam int PC_W   = 7;

  // operation codes of the shared unit
  localparam logic [3:0] OP_MUL  = 4'd0;
  localparam logic [3:0] OP_ADD  = 4'd1;
  localparam logic [3:0] OP_SUB  = 4'd2;
  localparam logic [3:0] OP_K2   = 4'd3;
  localparam logic [3:0] OP_K4   = 4'd4;
  localparam logic [3:0] OP_K6   = 4'd5;
  localparam logic [3:0] OP_DIV  = 4'd6;
  localparam logic [3:0] OP_CHK  = 4'd7;
  localparam logic [3:0] OP_ENDP = 4'd8;

  // scratch register file slots
  localparam logic [4:0] R_XD   = 5'd0;
  localparam logic [4:0] R_YD   = 5'd1;
  localparam logic [4:0] R_X    = 5'd2;
  localparam logic [4:0] R_Y    = 5'd3;
  localparam logic [4:0] R_K1   = 5'd4;
  localparam logic [4:0] R_K2   = 5'd5;
  localparam logic [4:0] R_P1   = 5'd6;
  localparam logic [4:0] R_P2   = 5'd7;
  localparam logic [4:0] R_ONE  = 5'd8;
  localparam logic [4:0] R_MX2  = 5'd9;
  localparam logic [4:0] R_MY2  = 5'd10;
  localparam logic [4:0] R_MXY  = 5'd11;
  localparam logic [4:0] R_RHO2 = 5'd12;
  localparam logic [4:0] R_RAD  = 5'd13;
  localparam logic [4:0] R_K2R  = 5'd14;
  localparam logic [4:0] R_OFFX = 5'd15;
  localparam logic [4:0] R_OFFY = 5'd16;
  localparam logic [4:0] R_J00  = 5'd17;
  localparam logic [4:0] R_J01  = 5'd18;
  localparam logic [4:0] R_J11  = 5'd19;
  localparam logic [4:0] R_E0   = 5'd20;
  localparam logic [4:0] R_E1   = 5'd21;
  localparam logic [4:0] R_ERR  = 5'd22;
  localparam logic [4:0] R_DET  = 5'd23;
  localparam logic [4:0] R_N0   = 5'd24;
  localparam logic [4:0] R_N1   = 5'd25;
  localparam logic [4:0] R_T0   = 5'd26;
  localparam logic [4:0] R_T1   = 5'd27;
  localparam logic [4:0] R_T2   = 5'd28;
  localparam logic [4:0] R_T3   = 5'd29;

  localparam logic [PC_W-1:0] PROG_LAST = 7'd83;

  typedef struct packed {
    logic [3:0]       op;
    logic [RF_AW-1:0] dst;
    logic [RF_AW-1:0] a;
    logic [RF_AW-1:0] b;
  } instr_t;

  function automatic instr_t mk(input logic [3:0] op, input logic [4:0] d,
                                input logic [4:0] a, input logic [4:0] b);
    instr_t w;
    w.op  = op;
    w.dst = d;
    w.a   = a;
    w.b   = b;
    return w;
  endfunction

  // saturate a 35-bit signed value to 32 bits
  function automatic logic [31:0] sat35(input logic signed [34:0] v);
    logic [31:0] r;
    if (v > 35'sd2147483647)       r = 32'h7FFF_FFFF;
    else if (v < -35'sd2147483648) r = 32'h8000_0000;
    else                           r = v[31:0];
    return r;
  endfunction

  // one Gauss-Newton pass
  function automatic instr_t prog_word(input logic [PC_W-1:0] pc);
    instr_t w;
    case (pc)
      7'd0:  w = mk(OP_MUL, R_MX2,  R_X,    R_X);
      7'd1:  w = mk(OP_MUL, R_MY2,  R_Y,    R_Y);
      7'd2:  w = mk(OP_MUL, R_MXY,  R_X,    R_Y);
      7'd3:  w = mk(OP_ADD, R_RHO2, R_MX2,  R_MY2);
      7'd4:  w = mk(OP_MUL, R_T0,   R_K1,   R_RHO2);
      7'd5:  w = mk(OP_MUL, R_T1,   R_RHO2, R_RHO2);
      7'd6:  w = mk(OP_MUL, R_T1,   R_K2,   R_T1);
      7'd7:  w = mk(OP_ADD, R_RAD,  R_T0,   R_T1);
      7'd8:  w = mk(OP_MUL, R_K2R,  R_K2,   R_RHO2);
      // x offset
      7'd9:  w = mk(OP_MUL, R_T0,   R_X,    R_RAD);
      7'd10: w = mk(OP_MUL, R_T1,   R_P1,   R_MXY);
      7'd11: w = mk(OP_K2,  R_T1,   R_T1,   R_T1);
      7'd12: w = mk(OP_ADD, R_T0,   R_T0,   R_T1);
      7'd13: w = mk(OP_K2,  R_T1,   R_MX2,  R_MX2);
      7'd14: w = mk(OP_ADD, R_T1,   R_RHO2, R_T1);
      7'd15: w = mk(OP_MUL, R_T1,   R_P2,   R_T1);
      7'd16: w = mk(OP_ADD, R_OFFX, R_T0,   R_T1);
      // y offset
      7'd17: w = mk(OP_MUL, R_T0,   R_Y,    R_RAD);
      7'd18: w = mk(OP_MUL, R_T1,   R_P2,   R_MXY);
      7'd19: w = mk(OP_K2,  R_T1,   R_T1,   R_T1);
      7'd20: w = mk(OP_ADD, R_T0,   R_T0,   R_T1);
      7'd21: w = mk(OP_K2,  R_T1,   R_MY2,  R_MY2);
      7'd22: w = mk(OP_ADD, R_T1,   R_RHO2, R_T1);
      7'd23: w = mk(OP_MUL, R_T1,   R_P1,   R_T1);
      7'd24: w = mk(OP_ADD, R_OFFY, R_T0,   R_T1);
      // j00
      7'd25: w = mk(OP_ADD, R_T0,   R_ONE,  R_RAD);
      7'd26: w = mk(OP_MUL, R_T1,   R_K1,   R_MX2);
      7'd27: w = mk(OP_K2,  R_T1,   R_T1,   R_T1);
      7'd28: w = mk(OP_ADD, R_T0,   R_T0,   R_T1);
      7'd29: w = mk(OP_MUL, R_T1,   R_K2R,  R_MX2);
      7'd30: w = mk(OP_K4,  R_T1,   R_T1,   R_T1);
      7'd31: w = mk(OP_MUL, R_T2,   R_P1,   R_Y);
      7'd32: w = mk(OP_K2,  R_T2,   R_T2,   R_T2);
      7'd33: w = mk(OP_MUL, R_T3,   R_P2,   R_X);
      7'd34: w = mk(OP_K6,  R_T3,   R_T3,   R_T3);
      7'd35: w = mk(OP_ADD, R_T2,   R_T2,   R_T3);
      7'd36: w = mk(OP_ADD, R_T1,   R_T1,   R_T2);
      7'd37: w = mk(OP_ADD, R_J00,  R_T0,   R_T1);
      // j01
      7'd38: w = mk(OP_MUL, R_T0,   R_K1,   R_MXY);
      7'd39: w = mk(OP_K2,  R_T0,   R_T0,   R_T0);
      7'd40: w = mk(OP_MUL, R_T1,   R_K2R,  R_MXY);
      7'd41: w = mk(OP_K4,  R_T1,   R_T1,   R_T1);
      7'd42: w = mk(OP_ADD, R_T0,   R_T0,   R_T1);
      7'd43: w = mk(OP_MUL, R_T1,   R_P1,   R_X);
      7'd44: w = mk(OP_K2,  R_T1,   R_T1,   R_T1);
      7'd45: w = mk(OP_MUL, R_T2,   R_P2,   R_Y);
      7'd46: w = mk(OP_K2,  R_T2,   R_T2,   R_T2);
      7'd47: w = mk(OP_ADD, R_T1,   R_T1,   R_T2);
      7'd48: w = mk(OP_ADD, R_J01,  R_T0,   R_T1);
      // j11
      7'd49: w = mk(OP_ADD, R_T0,   R_ONE,  R_RAD);
      7'd50: w = mk(OP_MUL, R_T1,   R_K1,   R_MY2);
      7'd51: w = mk(OP_K2,  R_T1,   R_T1,   R_T1);
      7'd52: w = mk(OP_ADD, R_T0,   R_T0,   R_T1);
      7'd53: w = mk(OP_MUL, R_T1,   R_K2R,  R_MY2);
      7'd54: w = mk(OP_K4,  R_T1,   R_T1,   R_T1);
      7'd55: w = mk(OP_MUL, R_T2,   R_P1,   R_Y);
      7'd56: w = mk(OP_K6,  R_T2,   R_T2,   R_T2);
      7'd57: w = mk(OP_MUL, R_T3,   R_P2,   R_X);
      7'd58: w = mk(OP_K2,  R_T3,   R_T3,   R_T3);
      7'd59: w = mk(OP_ADD, R_T2,   R_T2,   R_T3);
      7'd60: w = mk(OP_ADD, R_T1,   R_T1,   R_T2);
      7'd61: w = mk(OP_ADD, R_J11,  R_T0,   R_T1);
      // residual
      7'd62: w = mk(OP_SUB, R_T0,   R_XD,   R_X);
      7'd63: w = mk(OP_SUB, R_E0,   R_T0,   R_OFFX);
      7'd64: w = mk(OP_SUB, R_T0,   R_YD,   R_Y);
      7'd65: w = mk(OP_SUB, R_E1,   R_T0,   R_OFFY);
      7'd66: w = mk(OP_MUL, R_T0,   R_E0,   R_E0);
      7'd67: w = mk(OP_MUL, R_T1,   R_E1,   R_E1);
      7'd68: w = mk(OP_ADD, R_ERR,  R_T0,   R_T1);
      // determinant
      7'd69: w = mk(OP_MUL, R_T0,   R_J00,  R_J11);
      7'd70: w = mk(OP_MUL, R_T1,   R_J01,  R_J01);
      7'd71: w = mk(OP_SUB, R_DET,  R_T0,   R_T1);
      7'd72: w = mk(OP_CHK, R_DET,  R_DET,  R_DET);
      // step numerators
      7'd73: w = mk(OP_MUL, R_T0,   R_J11,  R_E0);
      7'd74: w = mk(OP_MUL, R_T1,   R_J01,  R_E1);
      7'd75: w = mk(OP_SUB, R_N0,   R_T0,   R_T1);
      7'd76: w = mk(OP_MUL, R_T0,   R_J00,  R_E1);
      7'd77: w = mk(OP_MUL, R_T1,   R_J01,  R_E0);
      7'd78: w = mk(OP_SUB, R_N1,   R_T0,   R_T1);
      // update
      7'd79: w = mk(OP_DIV, R_T0,   R_N0,   R_DET);
      7'd80: w = mk(OP_ADD, R_X,    R_X,    R_T0);
      7'd81: w = mk(OP_DIV, R_T0,   R_N1,   R_DET);
      7'd82: w = mk(OP_ADD, R_Y,    R_Y,    R_T0);
      7'd83: w = mk(OP_ENDP, R_ERR, R_ERR,  R_ERR);
      default: w = mk(OP_ENDP, R_ERR, R_ERR, R_ERR);
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// File: hdl/radtan_undistort_gauss_newton.sv
// Top level: radial-tangential undistortion by Gauss-Newton on one shared arithmetic unit.
// Operation: the point, coefficients and one are loaded, then each pass runs 33 multiplies,
//   47 add/scale ops, two divides and two test steps, for 1 to MAX_PASSES passes, and the
//   result is then presented in the output register.
// Throughput: one transaction at a time; in_stall stays high from accept until the result
//   is loaded into the output register. The pass program and its two long divides set the pace.
// Reset: rst_n synchronous active low; clears control and restores the register defaults.
`default_nettype none
module radtan_undistort_gauss_newton #(
  parameter int MAX_PASSES = rtgn_pkg::MAX_PASSES_DEF,
  parameter int FRAC_BITS  = rtgn_pkg::FRAC_BITS_DEF
) (
  input  wire                        clk,
  input  wire                        rst_n,
  // configuration port
  input  wire                        cfg_psel,
  input  wire                        cfg_penable,
  input  wire                        cfg_pwrite,
  input  wire [rtgn_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire [31:0]                 cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready,
  // input channel
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire signed [31:0]          in_distorted_x,
  input  wire signed [31:0]          in_distorted_y,
  // result channel
  output logic                       out_valid,
  input  wire                        out_stall,
  output logic signed [31:0]         out_undistorted_x,
  output logic signed [31:0]         out_undistorted_y,
  output logic                       out_converged,
  output logic [4:0]                 out_passes_used
);
  import rtgn_pkg::*;

  localparam int PW  = $clog2(MAX_PASSES + 1);
  localparam int NW  = 32 + FRAC_BITS;          // dividend width of the fixed-point divide
  localparam int DCW = $clog2(NW);
  localparam logic [31:0] ONE_Q = (FRAC_BITS >= 31) ? 32'h7FFF_FFFF
                                                    : 32'(64'd1 << FRAC_BITS);
  localparam logic signed [64:0] RND = 65'sd1 <<< (FRAC_BITS - 1);

  // sequencer states
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_LOAD = 4'd1;
  localparam logic [3:0] ST_RD   = 4'd2;
  localparam logic [3:0] ST_EX   = 4'd3;
  localparam logic [3:0] ST_MWB  = 4'd4;
  localparam logic [3:0] ST_DIV  = 4'd5;
  localparam logic [3:0] ST_DWB  = 4'd6;
  localparam logic [3:0] ST_FIN  = 4'd7;
  localparam logic [3:0] ST_EMIT = 4'd8;

  // ---------------------------------------------------------------------------
  // Configuration registers. A write lands at the access phase of the APB cycle;
  // addresses past the residual tolerance are ignored.
  // ---------------------------------------------------------------------------
  logic [31:0] k1_r, k2_r, p1_r, p2_r;
  logic [30:0] tol_r;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k1_r  <= '0;
      k2_r  <= '0;
      p1_r  <= '0;
      p2_r  <= '0;
      tol_r <= 31'd268;
    end else if (cfg_wr) begin
      case (cfg_idx)
        CFG_K1:  k1_r  <= cfg_pwdata;
        CFG_K2:  k2_r  <= cfg_pwdata;
        CFG_P1:  p1_r  <= cfg_pwdata;
        CFG_P2:  p2_r  <= cfg_pwdata;
        CFG_TOL: tol_r <= cfg_pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      CFG_K1:  cfg_prdata = k1_r;
      CFG_K2:  cfg_prdata = k2_r;
      CFG_P1:  cfg_prdata = p1_r;
      CFG_P2:  cfg_prdata = p2_r;
      CFG_TOL: cfg_prdata = {1'b0, tol_r};
      default: cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  logic [3:0]      state_r, state_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  logic [3:0]      ld_r, ld_nxt;
  logic [PW-1:0]   passes_r, passes_nxt;
  logic            conv_r, conv_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [31:0]     xd_r, yd_r;

  // scratch register file: one write port, two registered read ports
  logic [31:0]      rf [32];
  logic             rf_we;
  logic [RF_AW-1:0] rf_wa, ra, rb;
  logic [31:0]      rf_wd;
  logic [31:0]      opa_r, opb_r;

  instr_t ins;
  assign ins = prog_word(pc_r);
  assign ra  = (state_r == ST_FIN) ? R_X : ins.a;
  assign rb  = (state_r == ST_FIN) ? R_Y : ins.b;

  always_ff @(posedge clk) begin
    if (rf_we) rf[rf_wa] <= rf_wd;
    if (state_r == ST_RD || state_r == ST_FIN) begin
      opa_r <= rf[ra];
      opb_r <= rf[rb];
    end
  end

  // ---------------------------------------------------------------------------
  // Shared unit: saturating add/sub/scale, rounded multiply, long divider
  // ---------------------------------------------------------------------------
  logic signed [34:0] sa, sb, alu_s;
  logic [31:0]        alu_res;

  assign sa = 35'(signed'(opa_r));
  assign sb = 35'(signed'(opb_r));

  always_comb begin
    case (ins.op)
      OP_ADD:  alu_s = sa + sb;
      OP_SUB:  alu_s = sa - sb;
      OP_K2:   alu_s = sa <<< 1;
      OP_K4:   alu_s = sa <<< 2;
      OP_K6:   alu_s = (sa <<< 2) + (sa <<< 1);
      default: alu_s = sa;
    endcase
    alu_res = sat35(alu_s);
  end

  logic signed [63:0] prod_r;
  logic signed [64:0] mul_v, mul_q;
  logic [31:0]        mul_res;

  always_ff @(posedge clk) begin
    if (state_r == ST_EX) prod_r <= signed'(opa_r) * signed'(opb_r);
  end

  // round to nearest, ties up, then saturate
  always_comb begin
    mul_v = 65'(prod_r) + RND;
    mul_q = mul_v >>> FRAC_BITS;
    if (mul_q > 65'sd2147483647)       mul_res = 32'h7FFF_FFFF;
    else if (mul_q < -65'sd2147483648) mul_res = 32'h8000_0000;
    else                               mul_res = mul_q[31:0];
  end

  // restoring divider, one quotient bit per cycle, sticky overflow past 33 bits
  logic [NW-1:0]  dvd_r;
  logic [31:0]    rem_r, den_r;
  logic [32:0]    quo_r;
  logic           ovf_r, dneg_r;
  logic [DCW-1:0] dcnt_r;
  logic [32:0]    trial;
  logic           ge;
  logic [31:0]    n_mag, d_mag, div_res;
  logic           big;

  assign n_mag = opa_r[31] ? (32'd0 - opa_r) : opa_r;
  assign d_mag = opb_r[31] ? (32'd0 - opb_r) : opb_r;
  assign trial = {rem_r, dvd_r[NW-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (state_r == ST_EX) begin
      dvd_r  <= {n_mag, {FRAC_BITS{1'b0}}};
      rem_r  <= '0;
      quo_r  <= '0;
      ovf_r  <= 1'b0;
      den_r  <= d_mag;
      dneg_r <= opa_r[31] ^ opb_r[31];
      dcnt_r <= '0;
    end else if (state_r == ST_DIV) begin
      rem_r  <= ge ? 32'(trial - {1'b0, den_r}) : trial[31:0];
      quo_r  <= {quo_r[31:0], ge};
      ovf_r  <= ovf_r | quo_r[32];
      dvd_r  <= dvd_r << 1;
      dcnt_r <= dcnt_r + 1'b1;
    end
  end

  always_comb begin
    big = ovf_r | quo_r[32] | quo_r[31];
    if (dneg_r) div_res = big ? 32'h8000_0000 : (32'd0 - quo_r[31:0]);
    else        div_res = big ? 32'h7FFF_FFFF : quo_r[31:0];
  end

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  logic        in_acc;
  logic [31:0] ld_val;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid & ~in_stall;

  always_comb begin
    case (ld_r)
      4'd0, 4'd2: ld_val = xd_r;
      4'd1, 4'd3: ld_val = yd_r;
      4'd4:       ld_val = k1_r;
      4'd5:       ld_val = k2_r;
      4'd6:       ld_val = p1_r;
      4'd7:       ld_val = p2_r;
      default:    ld_val = ONE_Q;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    ld_nxt        = ld_r;
    passes_nxt    = passes_r;
    conv_nxt      = conv_r;
    out_valid_nxt = out_valid_r & out_stall;
    rf_we         = 1'b0;
    rf_wa         = ins.dst;
    rf_wd         = alu_res;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_LOAD;
          ld_nxt    = '0;
        end
      end
      // copy the point, coefficients and one into the register file
      ST_LOAD: begin
        rf_we  = 1'b1;
        rf_wa  = {1'b0, ld_r};
        rf_wd  = ld_val;
        ld_nxt = ld_r + 1'b1;
        if ({1'b0, ld_r} == R_ONE) begin
          state_nxt  = ST_RD;
          pc_nxt     = '0;
          passes_nxt = PW'(1);
          conv_nxt   = 1'b0;
        end
      end
      ST_RD: state_nxt = ST_EX;
      ST_EX: begin
        case (ins.op)
          OP_MUL: state_nxt = ST_MWB;
          OP_DIV: state_nxt = ST_DIV;
          OP_CHK: begin
            // singular Jacobian: stop with the estimate unchanged
            if (opa_r == '0) state_nxt = ST_FIN;
            else begin
              pc_nxt    = pc_r + 1'b1;
              state_nxt = ST_RD;
            end
          end
          OP_ENDP: begin
            if (signed'(opa_r) <= signed'({1'b0, tol_r})) begin
              conv_nxt  = 1'b1;
              state_nxt = ST_FIN;
            end else if (passes_r == PW'(MAX_PASSES)) begin
              state_nxt = ST_FIN;
            end else begin
              passes_nxt = passes_r + 1'b1;
              pc_nxt     = '0;
              state_nxt  = ST_RD;
            end
          end
          default: begin
            rf_we     = 1'b1;
            pc_nxt    = pc_r + 1'b1;
            state_nxt = ST_RD;
          end
        endcase
      end
      ST_MWB: begin
        rf_we     = 1'b1;
        rf_wd     = mul_res;
        pc_nxt    = pc_r + 1'b1;
        state_nxt = ST_RD;
      end
      ST_DIV: begin
        if (dcnt_r == DCW'(NW - 1)) state_nxt = ST_DWB;
      end
      ST_DWB: begin
        rf_we     = 1'b1;
        rf_wd     = div_res;
        pc_nxt    = pc_r + 1'b1;
        state_nxt = ST_RD;
      end
      ST_FIN: state_nxt = ST_EMIT;
      // hold here while an earlier result still waits downstream
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= '0;
      ld_r        <= '0;
      passes_r    <= '0;
      conv_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      ld_r        <= ld_nxt;
      passes_r    <= passes_nxt;
      conv_r      <= conv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  logic [PW+4:0] passes_ext;
  assign passes_ext = {5'd0, passes_r};

  always_ff @(posedge clk) begin
    if (in_acc) begin
      xd_r <= in_distorted_x;
      yd_r <= in_distorted_y;
    end
    if (state_r == ST_EMIT && (!out_valid_r || !out_stall)) begin
      out_undistorted_x <= opa_r;
      out_undistorted_y <= opb_r;
      out_converged     <= conv_r;
      out_passes_used   <= passes_ext[4:0];
    end
  end

  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  a_pass_cap: assert property (@(posedge clk) disable iff (!rst_n)
    passes_r <= PW'(MAX_PASSES))
    else $error("pass counter beyond cap");

  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT))
    else $error("result shown without finishing");

  a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_LOAD)
    else $error("accepted transaction did not start loading");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> dcnt_r <= DCW'(NW - 1))
    else $error("divider ran past its width");
`endif

endmodule
`default_nettype wire
